[rtl/effect_crossfade_sequencer_macros.svh]
// Assertion helpers shared by the crossfade sequencer.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef EFFECT_CROSSFADE_SEQUENCER_MACROS_SVH
`define EFFECT_CROSSFADE_SEQUENCER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ECS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ECS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ecs_pkg.sv]
package ecs_pkg;

  localparam int unsigned MAX_SOURCES = 16;

  localparam logic [31:0] FADE_MS_RESET = 32'd8000;

  // Cubic curve factor 3 * 2^16 and the quintic constant 10 * 2^32.
  localparam logic [19:0] CUBE_K    = 20'd196608;
  localparam logic [36:0] QUINT_TEN = 37'd10 << 32;

  typedef enum logic [1:0] {
    KIND_UPDATE  = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_DWELL = 2'd1,
    CFG_FADE  = 2'd2,
    CFG_CURVE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [15:0] low;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic        quintic;
    logic [15:0] frac;
  } curve_req_t;

  // (old*(255-w) + new*w) >> 8, rewritten as old*255 + (new-old)*w.
  function automatic logic [7:0] blend_ch(logic [7:0] old_c, logic [7:0] new_c,
                                          logic [7:0] w);
    logic signed [8:0]  diff;
    logic signed [17:0] mix;
    diff = $signed({1'b0, new_c}) - $signed({1'b0, old_c});
    mix  = $signed({2'b00, old_c, 8'h00}) - $signed({10'b0, old_c})
         + diff * $signed({1'b0, w});
    return mix[15:8];
  endfunction

endpackage

[rtl/ecs_if.sv]
interface ecs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic [7:0]  old_red;
  logic [7:0]  old_green;
  logic [7:0]  old_blue;
  logic [7:0]  new_red;
  logic [7:0]  new_green;
  logic [7:0]  new_blue;

  modport source (
    output valid, kind, now_ms, old_red, old_green, old_blue,
           new_red, new_green, new_blue,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, old_red, old_green, old_blue,
           new_red, new_green, new_blue,
    output ready
  );
endinterface

interface ecs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] current_index;
  logic [3:0] next_index;
  logic       fading;
  logic       restart_next;
  logic       fade_done;
  logic       no_sources;
  logic [7:0] weight;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (
    output valid, current_index, next_index, fading, restart_next, fade_done,
           no_sources, weight, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, current_index, next_index, fading, restart_next, fade_done,
           no_sources, weight, out_red, out_green, out_blue,
    output ready
  );
endinterface

[rtl/effect_crossfade_sequencer.sv]
// Channel   Direction  Contents
// in_i      sink       kind, now_ms, old and new pixel colours
// out_o     source     indices, fade flags and pulses, weight, blended colours
// cfg       write      effect_count, dwell_ms, fade_ms, curve_mode
//
// Pixel, restart and most update transactions finish in the cycle they are accepted.
// Starting a transition runs the 16-step divider for the modulo.
// An update during a fade runs 16 divider steps, then the shared multiplier
// in the curve unit, with either the cubic or the quintic curve.
// A transaction is taken only when the sequencer is idle and the result
// register is empty or being read; reset is asynchronous and active low.
`include "effect_crossfade_sequencer_macros.svh"

module effect_crossfade_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  ecs_in_if.sink      in_i,
  ecs_out_if.source   out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FDIV  = 2'd1;
  localparam logic [1:0] ST_CURVE = 2'd2;
  localparam logic [1:0] ST_MDIV  = 2'd3;

  logic [4:0]  count_q;
  logic [31:0] dwell_q;
  logic [31:0] fade_q;
  logic        curve_q;

  logic [1:0]  state_q, state_d;
  logic [31:0] dwell_start_q, dwell_start_d;
  logic [31:0] fade_start_q, fade_start_d;
  logic [3:0]  shown_q, shown_d;
  logic [3:0]  incoming_q, incoming_d;
  logic        in_fade_q, in_fade_d;
  logic [7:0]  weight_q, weight_d;
  logic [31:0] now_q;

  logic        out_valid_q;
  logic        finish;
  logic        res_restart, res_done, res_none;
  logic [7:0]  res_red, res_green, res_blue;

  logic        accept;
  logic [4:0]  cnt_used;
  logic [31:0] ref_time, limit, elapsed;
  logic        reached;

  ecs_pkg::div_req_t   div_req;
  ecs_pkg::curve_req_t curve_req;
  logic                div_done;
  logic [15:0]         div_quot;
  logic [31:0]         div_rem;
  logic                curve_done;
  logic [7:0]          curve_weight;

  ecs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  ecs_curve u_curve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (curve_req),
    .done_o   (curve_done),
    .weight_o (curve_weight)
  );

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign cnt_used = (int'(count_q) > ecs_pkg::MAX_SOURCES) ?
                    5'(ecs_pkg::MAX_SOURCES) : count_q;

  // One subtract and compare serves both the dwell and the fade check.
  assign ref_time = in_fade_q ? fade_start_q : dwell_start_q;
  assign limit    = in_fade_q ? fade_q : dwell_q;
  assign elapsed  = in_i.now_ms - ref_time;
  assign reached  = elapsed >= limit;

  always_comb begin
    state_d       = state_q;
    dwell_start_d = dwell_start_q;
    fade_start_d  = fade_start_q;
    shown_d       = shown_q;
    incoming_d    = incoming_q;
    in_fade_d     = in_fade_q;
    weight_d      = weight_q;
    finish        = 1'b0;
    res_restart   = 1'b0;
    res_done      = 1'b0;
    res_none      = 1'b0;
    res_red       = 8'd0;
    res_green     = 8'd0;
    res_blue      = 8'd0;
    div_req       = '0;
    curve_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.kind)
            ecs_pkg::KIND_UPDATE: begin
              if (cnt_used == 5'd0) begin
                res_none = 1'b1;
                finish   = 1'b1;
              end else if (in_fade_q) begin
                if (reached) begin
                  shown_d       = incoming_q;
                  in_fade_d     = 1'b0;
                  dwell_start_d = in_i.now_ms;
                  weight_d      = 8'd0;
                  res_done      = 1'b1;
                  finish        = 1'b1;
                end else begin
                  div_req.start    = 1'b1;
                  div_req.rem_init = elapsed;
                  div_req.low      = 16'd0;
                  div_req.divisor  = fade_q;
                  state_d          = ST_FDIV;
                end
              end else if (reached) begin
                // (shown + 1) mod count goes through the divider as a remainder.
                div_req.start    = 1'b1;
                div_req.rem_init = 32'd0;
                div_req.low      = {11'd0, {1'b0, shown_q} + 5'd1};
                div_req.divisor  = {27'd0, cnt_used};
                state_d          = ST_MDIV;
              end else begin
                finish = 1'b1;
              end
            end
            ecs_pkg::KIND_PIXEL: begin
              finish = 1'b1;
              if (in_fade_q) begin
                res_red   = ecs_pkg::blend_ch(in_i.old_red, in_i.new_red, weight_q);
                res_green = ecs_pkg::blend_ch(in_i.old_green, in_i.new_green, weight_q);
                res_blue  = ecs_pkg::blend_ch(in_i.old_blue, in_i.new_blue, weight_q);
              end else begin
                res_red   = in_i.old_red;
                res_green = in_i.old_green;
                res_blue  = in_i.old_blue;
              end
            end
            ecs_pkg::KIND_RESTART: begin
              shown_d       = 4'd0;
              incoming_d    = (cnt_used > 5'd1) ? 4'd1 : 4'd0;
              in_fade_d     = 1'b0;
              weight_d      = 8'd0;
              dwell_start_d = in_i.now_ms;
              finish        = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_FDIV: begin
        if (div_done) begin
          curve_req.start   = 1'b1;
          curve_req.quintic = curve_q;
          curve_req.frac    = div_quot;
          state_d           = ST_CURVE;
        end
      end
      ST_CURVE: begin
        if (curve_done) begin
          weight_d = curve_weight;
          finish   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          in_fade_d    = 1'b1;
          fade_start_d = now_q;
          incoming_d   = div_rem[3:0];
          weight_d     = 8'd0;
          res_restart  = 1'b1;
          finish       = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'd0;
      dwell_q <= 32'd0;
      fade_q  <= ecs_pkg::FADE_MS_RESET;
      curve_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ecs_pkg::CFG_COUNT: count_q <= cfg_data_i[4:0];
        ecs_pkg::CFG_DWELL: dwell_q <= cfg_data_i;
        ecs_pkg::CFG_FADE:  fade_q  <= cfg_data_i;
        ecs_pkg::CFG_CURVE: curve_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      dwell_start_q <= 32'd0;
      fade_start_q  <= 32'd0;
      shown_q       <= 4'd0;
      incoming_q    <= 4'd0;
      in_fade_q     <= 1'b0;
      weight_q      <= 8'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      dwell_start_q <= dwell_start_d;
      fade_start_q  <= fade_start_d;
      shown_q       <= shown_d;
      incoming_q    <= incoming_d;
      in_fade_q     <= in_fade_d;
      weight_q      <= weight_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= in_i.now_ms;
    end
    if (finish) begin
      out_o.current_index <= shown_d;
      out_o.next_index    <= incoming_d;
      out_o.fading        <= in_fade_d;
      out_o.restart_next  <= res_restart;
      out_o.fade_done     <= res_done;
      out_o.no_sources    <= res_none;
      out_o.weight        <= weight_d;
      out_o.out_red       <= res_red;
      out_o.out_green     <= res_green;
      out_o.out_blue      <= res_blue;
    end
  end

  assign out_o.valid = out_valid_q;

  `ECS_ASSERT_SAME(a_ready_only_idle, in_i.ready, state_q == ST_IDLE, "ready outside idle")
  `ECS_ASSERT_SAME(a_div_done_in_div, div_done, state_q == ST_FDIV || state_q == ST_MDIV, "stray divider result")
  `ECS_ASSERT_SAME(a_curve_done_in_curve, curve_done, state_q == ST_CURVE, "stray curve result")
  `ECS_ASSERT_SAME(a_weight_only_fading, weight_q != 8'd0, in_fade_q, "weight set outside a fade")
  `ECS_ASSERT_NEXT(a_long_item_empty_out, accept && state_d != ST_IDLE, !out_valid_q, "result register busy during a long transaction")

endmodule

[rtl/ecs_div.sv]
// Restoring divider, one quotient bit per cycle for sixteen quotient bits.
// The starting remainder must be below the divisor; the low bits are shifted
// in one at a time, so the same unit also gives a small value modulo a count.
module ecs_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ecs_pkg::div_req_t req_i,
  output logic             done_o,
  output logic [15:0]      quot_o,
  output logic [31:0]      rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [15:0] low_q;
  logic [15:0] quot_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_q, low_q[15]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q  <= req_i.rem_init;
      div_q  <= req_i.divisor;
      low_q  <= req_i.low;
      quot_q <= 16'd0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[31:0] : trial[31:0];
      low_q  <= {low_q[14:0], 1'b0};
      quot_q <= {quot_q[14:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[rtl/ecs_curve.sv]
// Fade curve sequencer around one registered 32 x 20 multiplier.
// Cubic: f*f, then f^2*(3*2^16 - 2f). Quintic: f*f, f^2*f, then c*q.
module ecs_curve (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecs_pkg::curve_req_t req_i,
  output logic               done_o,
  output logic [7:0]         weight_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQ   = 3'd1;
  localparam logic [2:0] PH_MUL2 = 3'd2;
  localparam logic [2:0] PH_Q    = 3'd3;
  localparam logic [2:0] PH_MUL3 = 3'd4;
  localparam logic [2:0] PH_WGT  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] f_q;
  logic        quintic_q;
  logic [31:0] f2_q;
  logic [15:0] c_q;
  logic [19:0] q_q;
  logic [51:0] prod_q;

  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic [51:0] mul_p;
  logic [36:0] q_full;
  logic [35:0] s_raw;
  logic [15:0] s_sat;
  logic [23:0] s_255;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: if (req_i.start) phase_d = PH_SQ;
      PH_SQ:   phase_d = PH_MUL2;
      PH_MUL2: phase_d = quintic_q ? PH_Q : PH_WGT;
      PH_Q:    phase_d = PH_MUL3;
      PH_MUL3: phase_d = PH_WGT;
      PH_WGT:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    mul_a = {16'd0, f_q};
    mul_b = {4'd0, f_q};
    case (phase_q)
      PH_MUL2: begin
        mul_a = prod_q[31:0];
        mul_b = quintic_q ? {4'd0, f_q} : ecs_pkg::CUBE_K - {3'd0, f_q, 1'b0};
      end
      PH_MUL3: begin
        mul_a = {16'd0, c_q};
        mul_b = q_q;
      end
      default: begin
        mul_a = {16'd0, f_q};
        mul_b = {4'd0, f_q};
      end
    endcase
  end

  assign mul_p = {20'd0, mul_a} * {32'd0, mul_b};

  // q = (10*2^32 + 6 f^2 - 15*2^16 f) >> 16 never goes negative for f below 2^16.
  assign q_full = ecs_pkg::QUINT_TEN + {3'd0, f2_q, 2'b00} + {4'd0, f2_q, 1'b0}
                - {1'b0, f_q, 20'd0} + {5'd0, f_q, 16'd0};

  assign s_raw = quintic_q ? prod_q[51:16] : {16'd0, prod_q[51:32]};
  assign s_sat = (s_raw > 36'd65535) ? 16'hFFFF : s_raw[15:0];
  assign s_255 = {s_sat, 8'h00} - {8'h00, s_sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && req_i.start) begin
      f_q       <= req_i.frac;
      quintic_q <= req_i.quintic;
    end
    if (phase_q == PH_MUL2) begin
      f2_q <= prod_q[31:0];
    end
    if (phase_q == PH_Q) begin
      c_q <= prod_q[47:32];
      q_q <= q_full[35:16];
    end
    if (phase_q == PH_SQ || phase_q == PH_MUL2 || phase_q == PH_MUL3) begin
      prod_q <= mul_p;
    end
  end

  assign done_o   = phase_q == PH_WGT;
  assign weight_o = s_255[23:16];

endmodule
